### rtl/core/utfdw_pkg.sv
// Package for the UTF-8 display width block: decoded character beat type and width table.
package utfdw_pkg;

    localparam int CP_BITS     = 21;
    localparam int GOT_BITS    = 3;
    localparam int OUT_BITS    = 16;
    localparam int WIDE_RANGES = 19;

    typedef logic [CP_BITS-1:0] cp_t;

    // One beat from the decoder to the accumulator.
    typedef struct packed {
        logic                has_char;
        cp_t                 cp;
        logic [GOT_BITS-1:0] got;
        logic                last;
    } char_evt_t;

    localparam cp_t WIDE_LO [WIDE_RANGES] = '{
        21'h03000, 21'h01100, 21'h02E80, 21'h03040, 21'h030A0, 21'h03100, 21'h03130,
        21'h03190, 21'h03200, 21'h03400, 21'h04E00, 21'h0AC00, 21'h0F900, 21'h0FE30,
        21'h0FF01, 21'h0FFE0, 21'h1F200, 21'h20000, 21'h30000
    };
    localparam cp_t WIDE_HI [WIDE_RANGES] = '{
        21'h03000, 21'h0115F, 21'h0303E, 21'h0309F, 21'h030FF, 21'h0312F, 21'h0318F,
        21'h031FF, 21'h033FF, 21'h04DBF, 21'h09FFF, 21'h0D7AF, 21'h0FAFF, 21'h0FE6F,
        21'h0FF60, 21'h0FFE6, 21'h1F2FF, 21'h2FFFF, 21'h3FFFF
    };

    function automatic logic is_wide(input cp_t cp);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < WIDE_RANGES; k++)
        begin
            if (cp >= WIDE_LO[k] && cp <= WIDE_HI[k])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Missing continuation bytes count as zero bits.
    function automatic cp_t pad_cp(input cp_t cp, input logic [1:0] pend);
        cp_t r;
        case (pend)
            2'd0:    r = cp;
            2'd1:    r = {cp[14:0], 6'b0};
            2'd2:    r = {cp[8:0], 12'b0};
            2'd3:    r = {cp[2:0], 18'b0};
            default: r = cp;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/utfdw_front.sv
// Byte decoder: gathers UTF-8 sequences into code point beats.
module utfdw_front
    import utfdw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic [7:0] text_byte,
    input  logic      last_byte,
    output logic      evt_push,
    output char_evt_t evt
);

    logic                ended_reg, ended_next;
    logic [1:0]          pend_reg, pend_next;
    logic [GOT_BITS-1:0] len_reg, len_next;
    cp_t                 pcp_reg, pcp_next;
    cp_t                 cp_cont;

    assign cp_cont = {pcp_reg[14:0], text_byte[5:0]};

    always_comb
    begin
        ended_next = ended_reg;
        pend_next  = pend_reg;
        len_next   = len_reg;
        pcp_next   = pcp_reg;
        evt        = '0;
        if (!ended_reg)
        begin
            if (text_byte == 8'h00)
            begin
                if (pend_reg != 2'd0)
                begin
                    evt.has_char = 1'b1;
                    evt.cp       = pad_cp(pcp_reg, pend_reg);
                    evt.got      = len_reg - {1'b0, pend_reg};
                end
                ended_next = 1'b1;
                pend_next  = 2'd0;
                len_next   = '0;
                pcp_next   = '0;
            end
            else if (pend_reg != 2'd0)
            begin
                pcp_next  = cp_cont;
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1)
                begin
                    evt.has_char = 1'b1;
                    evt.cp       = cp_cont;
                    evt.got      = len_reg;
                    len_next     = '0;
                    pcp_next     = '0;
                end
            end
            else if (text_byte < 8'h80)
            begin
                evt.has_char = 1'b1;
                evt.cp       = {13'b0, text_byte};
                evt.got      = 3'd1;
            end
            else if (text_byte < 8'hE0)
            begin
                pcp_next  = {16'b0, text_byte[4:0]};
                len_next  = 3'd2;
                pend_next = 2'd1;
            end
            else if (text_byte < 8'hF0)
            begin
                pcp_next  = {17'b0, text_byte[3:0]};
                len_next  = 3'd3;
                pend_next = 2'd2;
            end
            else
            begin
                pcp_next  = {18'b0, text_byte[2:0]};
                len_next  = 3'd4;
                pend_next = 2'd3;
            end
        end
        if (last_byte)
        begin
            if (!ended_next && pend_next != 2'd0)
            begin
                evt.has_char = 1'b1;
                evt.cp       = pad_cp(pcp_next, pend_next);
                evt.got      = len_next - {1'b0, pend_next};
            end
            evt.last   = 1'b1;
            ended_next = 1'b0;
            pend_next  = 2'd0;
            len_next   = '0;
            pcp_next   = '0;
        end
    end

    assign evt_push = accept && (evt.has_char || evt.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ended_reg <= 1'b0;
            pend_reg  <= 2'd0;
            len_reg   <= '0;
            pcp_reg   <= '0;
        end
        else if (accept)
        begin
            ended_reg <= ended_next;
            pend_reg  <= pend_next;
            len_reg   <= len_next;
            pcp_reg   <= pcp_next;
        end
    end

endmodule

### rtl/core/utfdw_evq.sv
// Two-entry queue of character beats between decoder and accumulator.
module utfdw_evq
    import utfdw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  char_evt_t wr_evt,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output char_evt_t rd_evt
);

    char_evt_t  mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_evt  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/core/utfdw_back.sv
// Accumulator: width sums, fit tracking and the two-entry result queue.
module utfdw_back
    import utfdw_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [OUT_BITS-1:0] max_columns,
    input  logic                evt_empty,
    input  char_evt_t           evt,
    output logic                evt_pop,
    output logic                empty,
    input  logic                pop,
    output logic [OUT_BITS-1:0] total_width,
    output logic [OUT_BITS-1:0] fit_bytes
);

    localparam int WB = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] width_sum_reg, width_sum_next;
    logic [COUNT_BITS-1:0] fit_w_reg, fit_w_next;
    logic [COUNT_BITS-1:0] fit_b_reg, fit_b_next;
    logic                  ovf_reg, ovf_next;

    logic [OUT_BITS-1:0] tot_mem [2];
    logic [OUT_BITS-1:0] fit_mem [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic                out_full;
    logic                res_push;
    logic                res_pop;

    logic [1:0]            cw;
    logic [COUNT_BITS:0]   sum_w;
    logic [COUNT_BITS:0]   sum_fw;
    logic [COUNT_BITS:0]   sum_fb;
    logic [OUT_BITS-1:0]   res_tot;
    logic [OUT_BITS-1:0]   res_fit;

    assign out_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign evt_pop  = !evt_empty && !(evt.last && out_full);
    assign res_push = evt_pop && evt.last;
    assign res_pop  = pop && !empty;

    assign cw     = is_wide(evt.cp) ? 2'd2 : 2'd1;
    assign sum_w  = {1'b0, width_sum_reg} + (COUNT_BITS+1)'(cw);
    assign sum_fw = {1'b0, fit_w_reg} + (COUNT_BITS+1)'(cw);
    assign sum_fb = {1'b0, fit_b_reg} + (COUNT_BITS+1)'(evt.got);

    always_comb
    begin
        width_sum_next = width_sum_reg;
        fit_w_next     = fit_w_reg;
        fit_b_next     = fit_b_reg;
        ovf_next       = ovf_reg;
        if (evt.has_char)
        begin
            width_sum_next = sum_w[COUNT_BITS] ? CNT_MAX : sum_w[COUNT_BITS-1:0];
            if (!ovf_reg)
            begin
                if ((COUNT_BITS+1 > OUT_BITS ? (COUNT_BITS+1) : OUT_BITS)'(sum_fw) >
                    (COUNT_BITS+1 > OUT_BITS ? (COUNT_BITS+1) : OUT_BITS)'(max_columns))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    fit_w_next = sum_fw[COUNT_BITS] ? CNT_MAX : sum_fw[COUNT_BITS-1:0];
                    fit_b_next = sum_fb[COUNT_BITS] ? CNT_MAX : sum_fb[COUNT_BITS-1:0];
                end
            end
        end
        res_tot = (WB'(width_sum_next) > WB'({OUT_BITS{1'b1}})) ? '1
                                                              : OUT_BITS'(width_sum_next);
        res_fit = (WB'(fit_b_next) > WB'({OUT_BITS{1'b1}})) ? '1 : OUT_BITS'(fit_b_next);
    end

    assign total_width = tot_mem[rd_ptr_reg];
    assign fit_bytes   = fit_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            tot_mem[wr_ptr_reg] <= res_tot;
            fit_mem[wr_ptr_reg] <= res_fit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_sum_reg <= '0;
            fit_w_reg     <= '0;
            fit_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            if (evt_pop)
            begin
                if (evt.last)
                begin
                    width_sum_reg <= '0;
                    fit_w_reg     <= '0;
                    fit_b_reg     <= '0;
                    ovf_reg       <= 1'b0;
                end
                else
                begin
                    width_sum_reg <= width_sum_next;
                    fit_w_reg     <= fit_w_next;
                    fit_b_reg     <= fit_b_next;
                    ovf_reg       <= ovf_next;
                end
            end
            if (res_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (res_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (res_push && !res_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (res_pop && !res_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/core/utf8_display_width_truncator.sv
// UTF-8 display width and truncation counter, top level.
//
// Input queue side: text_byte/last_byte are taken on a clock edge with push high and
// full low, one byte per beat. last_byte marks the end of a string; a zero byte ends
// the content and later bytes up to the last one are ignored.
// Result queue side: while empty is low, total_width and fit_bytes show the oldest
// result; pop with empty low takes it. One result per string, on its last byte.
// Config: max_columns is written when cfg_valid and cfg_ready are high; cfg_ready is
// always high. Reset value is 80. Write only while no string is in flight.
// Throughput: one byte per cycle unless results back up. The decoder feeds a two-entry
// beat queue; the accumulator drains one beat per cycle, so the rate is set by that
// single add and compare stage. A last beat's result is written to the result queue
// as the beat is popped. When the result receiver stalls, two results are held; the
// accumulator then stops on the next string end, the beat queue fills and full rises.
// Reset (rst_n low, asynchronous) clears all counters and both queues.
module utf8_display_width_truncator
    import utfdw_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          text_byte,
    input  logic                last_byte,
    output logic                empty,
    input  logic                pop,
    output logic [OUT_BITS-1:0] total_width,
    output logic [OUT_BITS-1:0] fit_bytes,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [OUT_BITS-1:0] max_columns
);

    logic [OUT_BITS-1:0] max_cols_reg;
    logic                accept;
    logic                evt_push;
    logic                evt_pop;
    logic                evt_empty;
    char_evt_t           wr_evt;
    char_evt_t           rd_evt;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cols_reg <= 16'd80;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_cols_reg <= max_columns;
        end
    end

    utfdw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .evt_push  (evt_push),
        .evt       (wr_evt)
    );

    utfdw_evq u_evq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (evt_push),
        .wr_evt (wr_evt),
        .full   (full),
        .pop    (evt_pop),
        .empty  (evt_empty),
        .rd_evt (rd_evt)
    );

    utfdw_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_columns (max_cols_reg),
        .evt_empty   (evt_empty),
        .evt         (rd_evt),
        .evt_pop     (evt_pop),
        .empty       (empty),
        .pop         (pop),
        .total_width (total_width),
        .fit_bytes   (fit_bytes)
    );

endmodule

### rtl/core/utfdw_checker.sv
// Port-level checker for the UTF-8 display width block, bound to the top level.
module utfdw_checker
    import utfdw_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input logic [OUT_BITS-1:0] total_width,
    input logic [OUT_BITS-1:0] fit_bytes,
    input logic                cfg_ready
);

    // A waiting result is not dropped or altered until popped.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(total_width) && $stable(fit_bytes)))
        else $error("result changed while waiting");

    // Any fitting byte belongs to a character with nonzero width.
    a_fit_has_width: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && fit_bytes != '0) |-> (total_width != '0))
        else $error("fit bytes without width");

    // Queues come out of reset empty.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (empty && !full))
        else $error("queue not empty after reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind utf8_display_width_truncator utfdw_checker u_utfdw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .total_width (total_width),
    .fit_bytes   (fit_bytes),
    .cfg_ready   (cfg_ready)
);
